// ===== rtl/spectral_mask_stereo_split_assert.svh =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split assertion macros
// Shared assertion forms for the checker of the block's ports.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_MASK_STEREO_SPLIT_ASSERT_SVH
`define SPECTRAL_MASK_STEREO_SPLIT_ASSERT_SVH

// Holds at every edge outside reset.
`define SMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the condition holds, the consequence holds at the next edge.
`define SMS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split package
// Shared types, register codes and constants of the block.
// ----------------------------------------------------------------------------
package sms_pkg;

	localparam int BIN_COUNT_DEF = 1025;

	typedef enum logic [1:0] {
		REG_WEIGHT = 2'd0,
		REG_GAIN   = 2'd1,
		REG_LEFT   = 2'd2,
		REG_RIGHT  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] weight;
		logic [31:0] gain;
		logic [10:0] left;
		logic [10:0] right;
	} cfg_t;

	localparam logic [15:0] WEIGHT_RST = 16'd0;
	localparam logic [31:0] GAIN_RST   = 32'd65536;

	localparam logic signed [33:0] Q30 = 34'sd1073741824;
	localparam logic signed [33:0] C9  = 34'sd172272;

	// Horner coefficients of the sine polynomial, highest order first.
	function automatic logic signed [33:0] sin_coef(input logic [1:0] j);
		logic signed [33:0] c;
		unique case (j)
			2'd0: c = -34'sd5026994;
			2'd1: c = 34'sd85569306;
			2'd2: c = -34'sd693598669;
			2'd3: c = 34'sd1686629713;
			default: c = 34'sd0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/sms_queue.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module sms_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/sms_front.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split front
// Accepts bins, counts them within the frame and marks those in the band.
// ----------------------------------------------------------------------------
module sms_front #(
	parameter int BIN_COUNT = 1025,
	localparam int IW = $clog2(BIN_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sms_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          in_last,
	input  logic          q_full,
	input  logic          clearing,
	output logic          push,
	output logic          band,
	output logic [IW-1:0] idx
);
	import sms_pkg::*;

	localparam int CW = (IW > 11) ? IW : 11;

	logic [IW-1:0] cnt_q;

	assign in_stall = clearing || q_full;
	assign push     = in_valid && !in_stall;
	assign idx      = cnt_q;
	assign band     = (CW'(cnt_q) >= CW'(cfg.left)) && (CW'(cnt_q) < CW'(cfg.right));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (in_last || cnt_q == IW'(BIN_COUNT - 1)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end
endmodule

// ===== rtl/sms_back.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split back
// Sequential engine: magnitude, smoothing, angle, mask and channel scaling.
// ----------------------------------------------------------------------------
module sms_back #(
	parameter int BIN_COUNT = 1025,
	localparam int IW = $clog2(BIN_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sms_pkg::cfg_t       cfg,
	output logic                clearing,
	input  logic                q_valid,
	output logic                q_pop,
	input  logic signed [23:0]  q_re,
	input  logic signed [23:0]  q_im,
	input  logic                q_last,
	input  logic                q_band,
	input  logic [IW-1:0]       q_idx,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [24:0]  first_re,
	output logic signed [24:0]  first_im,
	output logic signed [24:0]  second_re,
	output logic signed [24:0]  second_im,
	output logic                out_last
);
	import sms_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_RE, ST_SQ_IM, ST_ROOT_INIT, ST_ROOT, ST_AVG_A, ST_AVG_B,
		ST_AVG_SUM, ST_ANG_MUL, ST_ANG_ADD, ST_FOLD, ST_Z2_MUL, ST_Z2_SET,
		ST_P_MUL, ST_P_ACC, ST_S_MUL, ST_S_FIN, ST_SCL_MUL, ST_SCL_FIN, ST_DONE
	} state_t;

	state_t              state_q;
	logic signed [23:0]  re_q, im_q;
	logic                last_q, band_q;
	logic [IW-1:0]       idx_q;
	logic signed [67:0]  prod_q;
	logic [47:0]         sqv_q;
	logic [47:0]         root_q;
	logic [4:0]          k_q;
	logic [42:0]         acc_q;
	logic [24:0]         avg_q;
	logic [31:0]         angle_q;
	logic                neg_q;
	logic [30:0]         z_q;
	logic [30:0]         z2_q;
	logic signed [33:0]  p_q;
	logic [1:0]          j_q;
	logic [17:0]         m_q;
	logic [1:0]          part_q;
	logic signed [24:0]  res_q [4];
	logic                clr_q;
	logic [IW-1:0]       clr_cnt_q;

	logic [24:0]         mem_q [BIN_COUNT];
	logic [24:0]         rd_q;
	logic [IW-1:0]       rd_addr;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [24:0]         wr_data;

	logic signed [33:0]  mul_a, mul_b;
	logic signed [67:0]  mul_p;
	logic [16:0]         wc;
	logic [47:0]         bitv, trial;
	logic                ge;
	logic [42:0]         avg_sum;
	logic [31:0]         fold_t;
	logic signed [33:0]  s_tr, s_cl;
	logic [32:0]         m30;
	logic [17:0]         k2;
	logic signed [23:0]  sx;
	logic [23:0]         ax;
	logic [17:0]         kx;
	logic [24:0]         scl_p;
	logic                can_out;

	function automatic logic signed [33:0] div_q30(input logic signed [67:0] x);
		logic signed [67:0] t;
		t = x[67] ? x + 68'sd1073741823 : x;
		return 34'(t >>> 30);
	endfunction

	assign clearing = clr_q;
	assign q_pop    = state_q == ST_IDLE && q_valid && !clr_q;
	assign can_out  = !out_valid || !out_stall;

	assign wc      = 17'd65536 - {1'b0, cfg.weight};
	assign bitv    = 48'd1 << {k_q, 1'b0};
	assign trial   = root_q + bitv;
	assign ge      = sqv_q >= trial;
	assign avg_sum = acc_q + prod_q[42:0] + 43'd32768;
	assign fold_t  = (angle_q > 32'h8000_0000) ? (32'd0 - angle_q) : angle_q;
	assign s_tr    = div_q30(prod_q);
	assign s_cl    = (s_tr < 34'sd0) ? 34'sd0 : ((s_tr > Q30) ? Q30 : s_tr);
	assign m30     = neg_q ? 33'(Q30 - s_cl) : 33'(Q30 + s_cl);
	assign k2      = 18'd131072 - m_q;
	assign sx      = part_q[0] ? im_q : re_q;
	assign ax      = sx[23] ? 24'(-sx) : 24'(sx);
	assign kx      = part_q[1] ? k2 : m_q;
	assign scl_p   = 25'((prod_q[40:0] + 41'd32768) >> 16);

	always_comb begin
		unique case (state_q)
			ST_SQ_RE:   begin mul_a = 34'(re_q); mul_b = 34'(re_q); end
			ST_SQ_IM:   begin mul_a = 34'(im_q); mul_b = 34'(im_q); end
			ST_AVG_A:   begin
				mul_a = $signed({18'd0, cfg.weight});
				mul_b = $signed({9'd0, rd_q});
			end
			ST_AVG_B:   begin
				mul_a = $signed({17'd0, wc});
				mul_b = $signed({10'd0, root_q[23:0]});
			end
			ST_ANG_MUL: begin
				mul_a = $signed({9'd0, avg_q});
				mul_b = $signed({2'd0, cfg.gain});
			end
			ST_Z2_MUL:  begin mul_a = $signed({3'd0, z_q}); mul_b = $signed({3'd0, z_q}); end
			ST_P_MUL:   begin mul_a = p_q; mul_b = $signed({3'd0, z2_q}); end
			ST_S_MUL:   begin mul_a = $signed({3'd0, z_q}); mul_b = p_q; end
			ST_SCL_MUL: begin
				mul_a = $signed({10'd0, ax});
				mul_b = $signed({16'd0, kx});
			end
			default:    begin mul_a = 34'sd0; mul_b = 34'sd0; end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign rd_addr = (state_q == ST_IDLE) ? q_idx : idx_q;
	assign wr_en   = clr_q || state_q == ST_AVG_SUM;
	assign wr_addr = clr_q ? clr_cnt_q : idx_q;
	assign wr_data = clr_q ? 25'd0 : avg_sum[40:16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == IW'(BIN_COUNT - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			angle_q   <= 32'd0;
			out_valid <= 1'b0;
		end else begin
			prod_q <= mul_p;
			if (out_valid && !out_stall && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						re_q    <= q_re;
						im_q    <= q_im;
						last_q  <= q_last;
						band_q  <= q_band;
						idx_q   <= q_idx;
						state_q <= ST_SQ_RE;
					end
				end
				ST_SQ_RE: state_q <= ST_SQ_IM;
				ST_SQ_IM: begin
					sqv_q   <= prod_q[47:0];
					state_q <= ST_ROOT_INIT;
				end
				ST_ROOT_INIT: begin
					sqv_q   <= sqv_q + prod_q[47:0];
					root_q  <= 48'd0;
					k_q     <= 5'd23;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (ge) begin
						sqv_q  <= sqv_q - trial;
						root_q <= (root_q >> 1) + bitv;
					end else begin
						root_q <= root_q >> 1;
					end
					k_q <= k_q - 5'd1;
					if (k_q == 5'd0) begin
						state_q <= ST_AVG_A;
					end
				end
				ST_AVG_A: state_q <= ST_AVG_B;
				ST_AVG_B: begin
					acc_q   <= prod_q[42:0];
					state_q <= ST_AVG_SUM;
				end
				ST_AVG_SUM: begin
					avg_q   <= avg_sum[40:16];
					state_q <= ST_ANG_MUL;
				end
				ST_ANG_MUL: state_q <= ST_ANG_ADD;
				ST_ANG_ADD: begin
					angle_q <= angle_q + prod_q[31:0];
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					neg_q   <= fold_t > 32'h4000_0000;
					z_q     <= (fold_t > 32'h4000_0000) ? 31'(fold_t - 32'h4000_0000)
					                                    : 31'(32'h4000_0000 - fold_t);
					state_q <= ST_Z2_MUL;
				end
				ST_Z2_MUL: state_q <= ST_Z2_SET;
				ST_Z2_SET: begin
					z2_q    <= 31'(prod_q >>> 30);
					p_q     <= C9;
					j_q     <= 2'd0;
					state_q <= ST_P_MUL;
				end
				ST_P_MUL: state_q <= ST_P_ACC;
				ST_P_ACC: begin
					p_q <= sin_coef(j_q) + div_q30(prod_q);
					j_q <= j_q + 2'd1;
					state_q <= (j_q == 2'd3) ? ST_S_MUL : ST_P_MUL;
				end
				ST_S_MUL: state_q <= ST_S_FIN;
				ST_S_FIN: begin
					m_q    <= 18'((m30 + 33'd8192) >> 14);
					part_q <= 2'd0;
					if (band_q) begin
						state_q <= ST_SCL_MUL;
					end else begin
						res_q[0] <= 25'(re_q);
						res_q[1] <= 25'(im_q);
						res_q[2] <= 25'(re_q);
						res_q[3] <= 25'(im_q);
						state_q  <= ST_DONE;
					end
				end
				ST_SCL_MUL: state_q <= ST_SCL_FIN;
				ST_SCL_FIN: begin
					res_q[part_q] <= sx[23] ? -$signed(scl_p) : $signed(scl_p);
					part_q        <= part_q + 2'd1;
					state_q       <= (part_q == 2'd3) ? ST_DONE : ST_SCL_MUL;
				end
				ST_DONE: begin
					if (can_out) begin
						out_valid <= 1'b1;
						first_re  <= res_q[0];
						first_im  <= res_q[1];
						second_re <= res_q[2];
						second_im <= res_q[3];
						out_last  <= last_q;
						if (last_q) begin
							angle_q <= 32'd0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/spectral_mask_stereo_split.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split
// Splits spectrum bins into two channels with a smoothed-magnitude cosine mask.
// ----------------------------------------------------------------------------
// Each bin's processing is set by the 24-step square-root loop and the single
// multiplier that the back engine shares across all products; bins inside the
// split band take longer than those outside it, as they also scale channels.
// A two-entry queue lets the next bins be accepted while one is processed and
// while a finished beat waits at the output. After reset the block clears its
// smoothed-magnitude memory, all BIN_COUNT entries, one entry a cycle, and holds
// in_stall high meanwhile; configuration writes are taken at any time.
module spectral_mask_stereo_split #(
	parameter int BIN_COUNT = sms_pkg::BIN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] in_re,
	input  logic signed [23:0] in_im,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [24:0] first_re,
	output logic signed [24:0] first_im,
	output logic signed [24:0] second_re,
	output logic signed [24:0] second_im,
	output logic               out_last
);
	import sms_pkg::*;

	localparam int IW = $clog2(BIN_COUNT);
	localparam int QW = 24 + 24 + 1 + 1 + IW;

	cfg_t          cfg_q;
	logic          push, band, q_full, q_valid, q_pop, clearing;
	logic [IW-1:0] idx;
	logic [QW-1:0] q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight <= WEIGHT_RST;
			cfg_q.gain   <= GAIN_RST;
			cfg_q.left   <= 11'd0;
			cfg_q.right  <= 11'd0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WEIGHT: cfg_q.weight <= cfg_wdata[15:0];
				REG_GAIN:   cfg_q.gain   <= cfg_wdata;
				REG_LEFT:   cfg_q.left   <= cfg_wdata[10:0];
				REG_RIGHT:  cfg_q.right  <= cfg_wdata[10:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	sms_front #(.BIN_COUNT(BIN_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_last  (in_last),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.band     (band),
		.idx      (idx)
	);

	assign q_wdata = {band, idx, in_last, in_im, in_re};

	sms_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	sms_back #(.BIN_COUNT(BIN_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_re      (q_rdata[23:0]),
		.q_im      (q_rdata[47:24]),
		.q_last    (q_rdata[48]),
		.q_band    (q_rdata[QW-1]),
		.q_idx     (q_rdata[QW-2:49]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.first_re  (first_re),
		.first_im  (first_im),
		.second_re (second_re),
		.second_im (second_im),
		.out_last  (out_last)
	);
endmodule

// ===== rtl/sms_checker.sv =====
// ----------------------------------------------------------------------------
// Spectral mask stereo split checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "spectral_mask_stereo_split_assert.svh"

module sms_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [24:0] first_re,
	input logic signed [24:0] first_im,
	input logic signed [24:0] second_re,
	input logic signed [24:0] second_im,
	input logic               out_last
);
	// Both channels scale the same bin by a factor that is never negative.
	`SMS_ASSERT(a_sign_re, clk, arst_n, !out_valid || first_re[24] == second_re[24] || first_re == 25'sd0 || second_re == 25'sd0, "channel real parts differ in sign")
	`SMS_ASSERT(a_sign_im, clk, arst_n, !out_valid || first_im[24] == second_im[24] || first_im == 25'sd0 || second_im == 25'sd0, "channel imaginary parts differ in sign")
	`SMS_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && out_stall, out_valid, "output beat dropped while stalled")
	`SMS_ASSERT_NEXT(a_hold_data, clk, arst_n, out_valid && out_stall, $stable(first_re) && $stable(first_im) && $stable(second_re) && $stable(second_im) && $stable(out_last), "stalled output beat changed")
endmodule

bind spectral_mask_stereo_split sms_checker u_sms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.first_re  (first_re),
	.first_im  (first_im),
	.second_re (second_re),
	.second_im (second_im),
	.out_last  (out_last)
);

// ===== test/tb_spectral_mask_stereo_split.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spectral mask stereo split testbench
// Drives frames of spectrum bins through the block with random idling on both
// sides and a long output hold-off. It predicts every beat from its own model
// of the smoothing, angle and mask arithmetic and checks each output field.
// ----------------------------------------------------------------------------
module tb_spectral_mask_stereo_split;
	import sms_pkg::*;

	localparam int NBINS = 1025;
	localparam int IDLE_LIMIT = 6000;
	localparam longint QONE = 64'sd1073741824;

	typedef struct {
		logic signed [24:0] fre;
		logic signed [24:0] fim;
		logic signed [24:0] sre;
		logic signed [24:0] sim;
		logic               last;
	} split_bin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [23:0] in_re = '0;
	logic signed [23:0] in_im = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [24:0] first_re, first_im, second_re, second_im;
	logic out_last;

	logic [15:0] weight;
	logic [31:0] gain;
	logic [10:0] left_bin, right_bin;
	logic [24:0] avg_mag [NBINS];
	int unsigned bin_pos;
	logic [31:0] angle;

	split_bin_t pending_bins[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int hold_req = 0;
	int stall_cnt = 0;

	spectral_mask_stereo_split uut (.*);

	always #1 clk = ~clk;

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 46;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint cos_mask(logic [31:0] a);
		logic [31:0] t;
		bit neg;
		longint z, z2, p, s, m30;
		t = a;
		if (t > 32'h80000000) t = 32'd0 - t;
		neg = t > 32'h40000000;
		z = neg ? longint'({32'd0, t}) - QONE : QONE - longint'({32'd0, t});
		z2 = z * z / QONE;
		p = 64'sd172272;
		p = -64'sd5026994 + p * z2 / QONE;
		p = 64'sd85569306 + p * z2 / QONE;
		p = -64'sd693598669 + p * z2 / QONE;
		p = 64'sd1686629713 + p * z2 / QONE;
		s = z * p / QONE;
		if (s < 0) s = 0;
		if (s > QONE) s = QONE;
		m30 = neg ? QONE - s : QONE + s;
		return (m30 + 8192) >>> 14;
	endfunction

	function automatic logic [24:0] scale_part(longint x, longint k);
		longint ax, p, r;
		ax = x < 0 ? -x : x;
		p = (ax * k + 32768) >>> 16;
		r = x < 0 ? -p : p;
		return r[24:0];
	endfunction

	function automatic split_bin_t predict_split(longint re, longint im, logic last);
		split_bin_t e;
		int unsigned idx;
		longint mag, av, k;
		longint unsigned prod;
		idx = bin_pos;
		mag = isqrt(re * re + im * im);
		av = (longint'(weight) * longint'(avg_mag[idx]) + longint'(65536 - weight) * mag
			+ 32768) >>> 16;
		avg_mag[idx] = av[24:0];
		prod = longint'(av) * longint'({32'd0, gain});
		angle = angle + prod[31:0];
		k = cos_mask(angle);
		if (idx >= left_bin && idx < right_bin) begin
			e.fre = scale_part(re, k);
			e.fim = scale_part(im, k);
			e.sre = scale_part(re, 131072 - k);
			e.sim = scale_part(im, 131072 - k);
		end else begin
			e.fre = re[24:0];
			e.fim = im[24:0];
			e.sre = re[24:0];
			e.sim = im[24:0];
		end
		e.last = last;
		if (last) begin
			bin_pos = 0;
			angle = '0;
		end else begin
			bin_pos = (idx + 1 >= NBINS) ? 0 : idx + 1;
		end
		return e;
	endfunction

	task automatic send_bin(logic signed [23:0] re, logic signed [23:0] im, logic last);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_re <= re;
		in_im <= im;
		in_last <= last;
		do @(posedge clk); while (in_stall);
		pending_bins.push_back(predict_split(re, im, last));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] w, logic [31:0] g, logic [10:0] l, logic [10:0] r);
		cfg_wen <= 1'b1;
		cfg_index <= REG_WEIGHT;
		cfg_wdata <= {16'd0, w};
		@(posedge clk);
		cfg_index <= REG_GAIN;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_index <= REG_LEFT;
		cfg_wdata <= {21'd0, l};
		@(posedge clk);
		cfg_index <= REG_RIGHT;
		cfg_wdata <= {21'd0, r};
		@(posedge clk);
		cfg_wen <= 1'b0;
		weight = w;
		gain = g;
		left_bin = l;
		right_bin = r;
	endtask

	function automatic logic signed [23:0] rand_part();
		case ($urandom_range(0, 3))
			0: return 24'($urandom());
			1: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
		endcase
	endfunction

	task automatic send_frame(int len);
		for (int i = 0; i < len; i++) send_bin(rand_part(), rand_part(), i == len - 1);
	endtask

	task automatic test_defaults();
		send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_bin(24'sh800000, 24'sh800000, 1'b0);
		send_bin(24'sd0, 24'sd0, 1'b0);
		send_bin(-24'sd1, 24'sd1, 1'b1);
		wait_drained();
	endtask

	task automatic test_split_extremes();
		set_config(16'hFFFF, 32'hFFFFFFFF, 11'd0, 11'd1025);
		send_bin(24'sh7FFFFF, 24'sh800000, 1'b0);
		send_bin(24'sh800000, 24'sh7FFFFF, 1'b0);
		send_bin(24'sd12345, -24'sd777, 1'b0);
		send_bin(-24'sd1, -24'sd1, 1'b1);
		wait_drained();
		set_config(16'd0, 32'd0, 11'd1, 11'd3);
		send_bin(24'sd1000, -24'sd1000, 1'b0);
		send_bin(24'sh7FFFFF, 24'sh800000, 1'b0);
		send_bin(24'sd3, -24'sd3, 1'b0);
		send_bin(24'sd5, 24'sd5, 1'b1);
		wait_drained();
		set_config(16'd32768, 32'h40000000, 11'd0, 11'd1025);
		send_bin(24'sd1, 24'sd0, 1'b0);
		send_bin(24'sd0, 24'sd1, 1'b0);
		send_bin(24'sd2, 24'sd0, 1'b1);
		wait_drained();
	endtask

	task automatic test_empty_band();
		set_config(16'd1000, 32'h12345678, 11'd1025, 11'd0);
		send_bin(24'sh7FFFFF, 24'sd99, 1'b0);
		send_bin(-24'sd4096, 24'sh800000, 1'b1);
		wait_drained();
	endtask

	task automatic test_overlong_frame();
		set_config(16'($urandom()), $urandom(), 11'd1000, 11'd1025);
		for (int i = 0; i < 1030; i++) begin
			if (i % 100 == 0) quiet = $urandom_range(0, 3) == 0;
			send_bin(rand_part(), rand_part(), 1'b0);
		end
		send_bin(rand_part(), rand_part(), 1'b1);
		quiet = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_frames();
		logic [10:0] l, r;
		for (int s = 0; s < 4; s++) begin
			l = 11'($urandom_range(0, 40));
			r = $urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 1025))
				: 11'(l + $urandom_range(1, 30));
			set_config(16'($urandom()), $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 65535),
				l, r);
			for (int f = 0; f < 4; f++) begin
				quiet = $urandom_range(0, 3) == 0;
				send_frame($urandom_range(1, 20));
			end
			quiet = 1'b0;
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		set_config(16'd40000, 32'h00F00000, 11'd2, 11'd10);
		hold_req = 400;
		send_frame(20);
		wait_drained();
	endtask

	task automatic test_no_idle();
		quiet = 1'b1;
		set_config(16'd65535, 32'h7FFFFFFF, 11'd0, 11'd1025);
		send_frame(30);
		send_frame(30);
		wait_drained();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_cnt = 0;
		end else if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req--;
		end else if (stall_cnt > 0) begin
			out_stall <= 1'b1;
			stall_cnt--;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_cnt = $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		split_bin_t e;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("spectral_mask_stereo_split verification failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bins.size() == 0) begin
				$display("%0t: unexpected beat fr=%0d fi=%0d sr=%0d si=%0d last=%0b", $time,
					first_re, first_im, second_re, second_im, out_last);
				errors++;
			end else begin
				e = pending_bins.pop_front();
				if (first_re !== e.fre) begin
					$display("%0t: first_re expected %0d actual %0d", $time, e.fre, first_re);
					errors++;
				end
				if (first_im !== e.fim) begin
					$display("%0t: first_im expected %0d actual %0d", $time, e.fim, first_im);
					errors++;
				end
				if (second_re !== e.sre) begin
					$display("%0t: second_re expected %0d actual %0d", $time, e.sre, second_re);
					errors++;
				end
				if (second_im !== e.sim) begin
					$display("%0t: second_im expected %0d actual %0d", $time, e.sim, second_im);
					errors++;
				end
				if (out_last !== e.last) begin
					$display("%0t: out_last expected %0b actual %0b", $time, e.last, out_last);
					errors++;
				end
			end
		end
	end

	initial begin
		weight = WEIGHT_RST;
		gain = GAIN_RST;
		left_bin = '0;
		right_bin = '0;
		bin_pos = 0;
		angle = '0;
		foreach (avg_mag[i]) avg_mag[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_split_extremes();
		test_empty_band();
		test_random_frames();
		test_backpressure();
		test_overlong_frame();
		test_no_idle();
		if (errors == 0) begin
			$display("spectral_mask_stereo_split verification clean");
		end else begin
			$display("spectral_mask_stereo_split verification failed");
		end
		$finish;
	end

endmodule

// ===== spectral_mask_stereo_split.f =====
+incdir+rtl
rtl/sms_pkg.sv
rtl/sms_queue.sv
rtl/sms_front.sv
rtl/sms_back.sv
rtl/spectral_mask_stereo_split.sv
rtl/sms_checker.sv
test/tb_spectral_mask_stereo_split.sv
